/* hdl/two_channel_lamp_fade_mixer_defines.svh */
// Assertion macros shared by the lamp fade mixer RTL.
`ifndef TWO_CHANNEL_LAMP_FADE_MIXER_DEFINES_SVH
`define TWO_CHANNEL_LAMP_FADE_MIXER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that an expression holds at every clock edge outside reset.
`define TCLFM_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lamp fade mixer: invariant violated");

// Checks that a condition implies a consequence in the same cycle.
`define TCLFM_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lamp fade mixer: implication violated");

`else

`define TCLFM_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define TCLFM_ASSERT_IMP(lbl, clk, rst_n, pre, post)

`endif

`endif

/* hdl/tclfm_pkg.sv */
// Types and constants shared by the lamp fade mixer modules.
package tclfm_pkg;

    localparam int FULL_DUTY_DEFAULT = 1000;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_BRIGHTNESS_MAX     = 3'd0,
        CFG_BRIGHTNESS_MIN     = 3'd1,
        CFG_COLOUR_MAX         = 3'd2,
        CFG_KEEP_CODE          = 3'd3,
        CFG_OFF_CODE           = 3'd4,
        CFG_DIMMER_ON          = 3'd5,
        CFG_DEFAULT_BRIGHTNESS = 3'd6,
        CFG_DEFAULT_COLOUR     = 3'd7
    } t_cfg_index;

    // Request kinds.
    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Register reset values.
    localparam logic [6:0] BRIGHTNESS_MAX_RST = 7'd100;
    localparam logic [6:0] BRIGHTNESS_MIN_RST = 7'd1;
    localparam logic [6:0] COLOUR_MAX_RST     = 7'd100;
    localparam logic [7:0] KEEP_CODE_RST      = 8'd255;
    localparam logic [7:0] OFF_CODE_RST       = 8'd0;
    localparam logic [6:0] DEFAULT_LEVEL_RST  = 7'd50;
    localparam logic [6:0] DEFAULT_COLOUR_RST = 7'd50;

    // Fade length and pacing thresholds.
    localparam logic [8:0] FADE_STEPS  = 9'd500;
    localparam logic [8:0] PACE_TH_20  = 9'd496;
    localparam logic [8:0] PACE_TH_16  = 9'd488;
    localparam logic [8:0] PACE_TH_6   = 9'd468;
    localparam logic [8:0] PACE_TH_4   = 9'd428;
    localparam logic [8:0] PACE_TH_2   = 9'd368;
    localparam logic [4:0] PACE_LIMIT  = 5'd20;
    localparam logic [15:0] ACC_SCALE  = 16'd500;

    // Reciprocals: x/500 = ((x>>2)*R125_S21)>>21 for 16-bit x,
    // x/50 = ((x>>1)*R25_S20)>>20 for 16-bit x,
    // x/1000 = ((x>>3)*R125_S25)>>25 for 21-bit x.
    localparam logic [14:0] R125_S21 = 15'd16778;
    localparam logic [15:0] R25_S20  = 16'd41944;
    localparam logic [18:0] R125_S25 = 19'd268436;

    localparam logic [10:0] PERMILLE_FULL = 11'd1000;

    // One fade step handed to the duty pipeline.
    typedef struct packed {
        logic [15:0] level_accum;
        logic [15:0] colour_accum;
        logic [6:0]  level;
        logic [6:0]  colour;
    } t_step;

endpackage

/* hdl/tclfm_duty_pipe.sv */
// Duty pipeline: turns fade step accumulators into warm and cold duties.
module tclfm_duty_pipe
    import tclfm_pkg::*;
#(
    parameter int FULL_DUTY = FULL_DUTY_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step_valid,
    input  t_step       i_step,
    output logic        o_ready,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_warm_duty,
    output logic        o_warm_active,
    output logic [9:0]  o_cold_duty,
    output logic        o_cold_active,
    output logic [6:0]  o_level_now,
    output logic [6:0]  o_colour_now
);

    localparam logic [10:0] FULL = 11'(FULL_DUTY);

    function automatic logic [9:0] finish_duty(input logic [10:0] d);
        logic [11:0] v;
        v = (d == FULL) ? ({1'b0, d} + 12'd4) : {1'b0, d};
        return (v > 12'd1023) ? 10'd1023 : v[9:0];
    endfunction

    logic r_v1, r_v2, r_v3, r_vo;
    logic ld1, ld2, ld3, ld_o;

    logic [15:0] r_s1_lacc, r_s1_cacc;
    logic [6:0]  r_s1_level, r_s1_colour;
    logic [10:0] r_s2_eb, r_s2_ec;
    logic [6:0]  r_s2_level, r_s2_colour;
    logic [20:0] r_s3_pw, r_s3_pc;
    logic [6:0]  r_s3_level, r_s3_colour;
    logic [9:0]  r_warm, r_cold;
    logic [6:0]  r_level, r_colour;

    logic [30:0] eb_prod, ec_prod;
    logic [10:0] n_eb, n_ec;
    logic [21:0] pw_full;
    logic [20:0] n_pw, n_pc;
    logic [9:0]  cold_gap;
    logic [36:0] qw_prod, qc_prod;
    logic [9:0]  n_warm, n_cold;

    assign ld_o    = !r_vo || !i_out_stall;
    assign ld3     = !r_v3 || ld_o;
    assign ld2     = !r_v2 || ld3;
    assign ld1     = !r_v1 || ld2;
    assign o_ready = ld1;

    // Stage 1: brightness and colour in tenths of a percent.
    always_comb begin
        eb_prod = 31'(r_s1_lacc[15:1]) * 31'(R25_S20);
        ec_prod = 31'(r_s1_cacc[15:1]) * 31'(R25_S20);
        n_eb    = eb_prod[30:20];
        n_ec    = ec_prod[30:20];
    end

    // Stage 2: raw products before scaling by one thousandth.
    always_comb begin
        pw_full  = 22'(r_s2_eb) * 22'(r_s2_ec);
        n_pw     = pw_full[20:0];
        cold_gap = 10'(PERMILLE_FULL - r_s2_ec);
        if (r_s2_ec > PERMILLE_FULL) begin
            n_pc = '0;
        end else begin
            n_pc = 21'(cold_gap) * 21'(r_s2_eb);
        end
    end

    // Stage 3: divide by one thousand and finish the duties.
    always_comb begin
        qw_prod = 37'(r_s3_pw[20:3]) * 37'(R125_S25);
        qc_prod = 37'(r_s3_pc[20:3]) * 37'(R125_S25);
        n_warm  = finish_duty(qw_prod[35:25]);
        n_cold  = finish_duty(qc_prod[35:25]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_step_valid;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
            if (ld_o) r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_s1_lacc   <= i_step.level_accum;
            r_s1_cacc   <= i_step.colour_accum;
            r_s1_level  <= i_step.level;
            r_s1_colour <= i_step.colour;
        end
        if (ld2) begin
            r_s2_eb     <= n_eb;
            r_s2_ec     <= n_ec;
            r_s2_level  <= r_s1_level;
            r_s2_colour <= r_s1_colour;
        end
        if (ld3) begin
            r_s3_pw     <= n_pw;
            r_s3_pc     <= n_pc;
            r_s3_level  <= r_s2_level;
            r_s3_colour <= r_s2_colour;
        end
        if (ld_o) begin
            r_warm   <= n_warm;
            r_cold   <= n_cold;
            r_level  <= r_s3_level;
            r_colour <= r_s3_colour;
        end
    end

    assign o_out_valid   = r_vo;
    assign o_warm_duty   = r_warm;
    assign o_warm_active = (r_warm != 10'd0);
    assign o_cold_duty   = r_cold;
    assign o_cold_active = (r_cold != 10'd0);
    assign o_level_now   = r_level;
    assign o_colour_now  = r_colour;

endmodule

/* hdl/two_channel_lamp_fade_mixer.sv */
// Top level of the two-channel warm/cold lamp fade mixer.
//
//  Channel  Direction  Handshake                 Payload
//  in       request    i_in_valid / o_in_stall   req_type, set_brightness, target_colour
//  out      result     o_out_valid / i_out_stall warm/cold duty and active, level, colour
//  cfg      write      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One request is taken in every cycle while o_in_stall is low. A tick that
// completes a fade step is taken into the first of a four-register duty
// pipeline, whose depth is set by the multiply chain of the duty math, and
// is valid on the outputs once it reaches the last register. Reset is
// synchronous and active low. A stalled result holds the pipeline; requests are
// stalled only while all four pipeline registers hold a result and the
// result at the output is itself stalled.
`include "two_channel_lamp_fade_mixer_defines.svh"

module two_channel_lamp_fade_mixer
    import tclfm_pkg::*;
#(
    parameter int FULL_DUTY = FULL_DUTY_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_set_brightness,
    input  logic [7:0]  i_target_colour,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_warm_duty,
    output logic        o_warm_active,
    output logic [9:0]  o_cold_duty,
    output logic        o_cold_active,
    output logic [6:0]  o_level_now,
    output logic [6:0]  o_colour_now,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // Configuration registers. The default brightness and colour only
    // matter at reset, so writes to them have no lasting effect and they
    // are seeded from their reset values.
    logic [6:0] r_bright_max, r_bright_min, r_colour_max;
    logic [7:0] r_keep_code, r_off_code;
    logic       r_dimmer_on;

    // Fade state.
    logic        r_fading, n_fading;
    logic [8:0]  r_step_index, n_step_index;
    logic [4:0]  r_pace_count, n_pace_count;
    logic [15:0] r_level_accum, n_level_accum;
    logic [15:0] r_colour_accum, n_colour_accum;
    logic [7:0]  r_level_delta, n_level_delta;
    logic [7:0]  r_colour_delta, n_colour_delta;
    logic [6:0]  r_preset_level, n_preset_level;
    logic [6:0]  r_preset_colour, n_preset_colour;
    logic [6:0]  r_current_level, n_current_level;
    logic [6:0]  r_current_colour, n_current_colour;

    logic        pipe_ready;
    logic        accept;
    logic        step_go;
    t_step       step_data;

    logic [7:0]  req_b, req_c;
    logic        req_ok;
    logic [4:0]  pace_wait, pace_next;
    logic [8:0]  step_next;
    logic [15:0] lacc_next, cacc_next;
    logic [28:0] lvl_prod, col_prod;

    assign o_in_stall = !pipe_ready;
    assign accept     = i_in_valid && pipe_ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright_max <= BRIGHTNESS_MAX_RST;
            r_bright_min <= BRIGHTNESS_MIN_RST;
            r_colour_max <= COLOUR_MAX_RST;
            r_keep_code  <= KEEP_CODE_RST;
            r_off_code   <= OFF_CODE_RST;
            r_dimmer_on  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_BRIGHTNESS_MAX:     r_bright_max <= i_cfg_data[6:0];
                CFG_BRIGHTNESS_MIN:     r_bright_min <= i_cfg_data[6:0];
                CFG_COLOUR_MAX:         r_colour_max <= i_cfg_data[6:0];
                CFG_KEEP_CODE:          r_keep_code  <= i_cfg_data;
                CFG_OFF_CODE:           r_off_code   <= i_cfg_data;
                CFG_DIMMER_ON:          r_dimmer_on  <= i_cfg_data[0];
                CFG_DEFAULT_BRIGHTNESS: ;
                CFG_DEFAULT_COLOUR:     ;
                default:                ;
            endcase
        end
    end

    // Keep codes fall back to the stored presets before validation.
    always_comb begin
        req_b  = (i_set_brightness == r_keep_code) ? {1'b0, r_preset_level}
                                                   : i_set_brightness;
        req_c  = (i_target_colour == r_keep_code) ? {1'b0, r_preset_colour}
                                                  : i_target_colour;
        req_ok = (req_b <= {1'b0, r_bright_max}) && (req_b >= {1'b0, r_bright_min})
              && (req_c <= {1'b0, r_colour_max}) && r_dimmer_on;
    end

    // Steps near the end of a fade are held for several ticks each.
    always_comb begin
        if (r_step_index >= PACE_TH_20) begin
            pace_wait = 5'd20;
        end else if (r_step_index >= PACE_TH_16) begin
            pace_wait = 5'd16;
        end else if (r_step_index >= PACE_TH_6) begin
            pace_wait = 5'd6;
        end else if (r_step_index >= PACE_TH_4) begin
            pace_wait = 5'd4;
        end else if (r_step_index >= PACE_TH_2) begin
            pace_wait = 5'd2;
        end else begin
            pace_wait = 5'd0;
        end
        pace_next = r_pace_count + 5'd1;
    end

    // Accumulators advance by the sign-extended delta each step, and the
    // new current level is the accumulator divided by five hundred.
    always_comb begin
        step_next = r_step_index + 9'd1;
        lacc_next = r_level_accum + {{8{r_level_delta[7]}}, r_level_delta};
        cacc_next = r_colour_accum + {{8{r_colour_delta[7]}}, r_colour_delta};
        lvl_prod  = 29'(lacc_next[15:2]) * 29'(R125_S21);
        col_prod  = 29'(cacc_next[15:2]) * 29'(R125_S21);
    end

    always_comb begin
        n_fading         = r_fading;
        n_step_index     = r_step_index;
        n_pace_count     = r_pace_count;
        n_level_accum    = r_level_accum;
        n_colour_accum   = r_colour_accum;
        n_level_delta    = r_level_delta;
        n_colour_delta   = r_colour_delta;
        n_preset_level   = r_preset_level;
        n_preset_colour  = r_preset_colour;
        n_current_level  = r_current_level;
        n_current_colour = r_current_colour;
        step_go          = 1'b0;

        if (accept && (i_req_type == REQ_SET)) begin
            // The accumulators are reloaded from the current level even
            // when the request is rejected or arrives mid-fade.
            n_level_accum  = 16'(16'(r_current_level) * ACC_SCALE);
            n_colour_accum = 16'(16'(r_current_colour) * ACC_SCALE);
            if (req_ok) begin
                n_preset_level  = req_b[6:0];
                n_preset_colour = req_c[6:0];
                n_level_delta   = req_b - {1'b0, r_current_level};
                n_colour_delta  = req_c - {1'b0, r_current_colour};
                n_fading        = 1'b1;
                n_step_index    = '0;
            end else if (req_b == r_off_code) begin
                n_level_delta   = 8'd0 - {1'b0, r_current_level};
                n_colour_delta  = '0;
                n_fading        = 1'b1;
                n_step_index    = '0;
            end
        end else if (accept && (i_req_type == REQ_TICK) && r_fading) begin
            if (pace_wait == 5'd0) begin
                step_go = 1'b1;
            end else if (pace_next < pace_wait) begin
                n_pace_count = pace_next;
            end else begin
                n_pace_count = '0;
                step_go      = 1'b1;
            end
            if (step_go) begin
                n_level_accum    = lacc_next;
                n_colour_accum   = cacc_next;
                n_current_level  = (lvl_prod[28:21] > 8'd127) ? 7'd127 : lvl_prod[27:21];
                n_current_colour = (col_prod[28:21] > 8'd127) ? 7'd127 : col_prod[27:21];
                if (step_next >= FADE_STEPS) begin
                    n_fading     = 1'b0;
                    n_step_index = '0;
                end else begin
                    n_step_index = step_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fading         <= 1'b0;
            r_step_index     <= '0;
            r_pace_count     <= '0;
            r_level_accum    <= '0;
            r_colour_accum   <= '0;
            r_level_delta    <= '0;
            r_colour_delta   <= '0;
            r_preset_level   <= DEFAULT_LEVEL_RST;
            r_preset_colour  <= DEFAULT_COLOUR_RST;
            r_current_level  <= '0;
            r_current_colour <= DEFAULT_COLOUR_RST;
        end else begin
            r_fading         <= n_fading;
            r_step_index     <= n_step_index;
            r_pace_count     <= n_pace_count;
            r_level_accum    <= n_level_accum;
            r_colour_accum   <= n_colour_accum;
            r_level_delta    <= n_level_delta;
            r_colour_delta   <= n_colour_delta;
            r_preset_level   <= n_preset_level;
            r_preset_colour  <= n_preset_colour;
            r_current_level  <= n_current_level;
            r_current_colour <= n_current_colour;
        end
    end

    // The step hands its fresh accumulators and levels to the duty math.
    always_comb begin
        step_data.level_accum  = n_level_accum;
        step_data.colour_accum = n_colour_accum;
        step_data.level        = n_current_level;
        step_data.colour       = n_current_colour;
    end

    tclfm_duty_pipe #(
        .FULL_DUTY (FULL_DUTY)
    ) u_duty_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step_valid  (step_go),
        .i_step        (step_data),
        .o_ready       (pipe_ready),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_warm_duty   (o_warm_duty),
        .o_warm_active (o_warm_active),
        .o_cold_duty   (o_cold_duty),
        .o_cold_active (o_cold_active),
        .o_level_now   (o_level_now),
        .o_colour_now  (o_colour_now)
    );

    // A stable lamp always sits at step zero.
    `TCLFM_ASSERT_IMP(a_idle_step_zero, i_clk, i_rst_n, !r_fading, r_step_index == 9'd0)
    // The step count never reaches the fade length.
    `TCLFM_ASSERT_ALWAYS(a_step_range, i_clk, i_rst_n, r_step_index < FADE_STEPS)
    // The pace counter never exceeds the longest step hold.
    `TCLFM_ASSERT_ALWAYS(a_pace_range, i_clk, i_rst_n, r_pace_count < PACE_LIMIT)
    // Requests are held back only behind a result that is itself held.
    `TCLFM_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

endmodule

/* test/tb_two_channel_lamp_fade_mixer.sv */
// Self-checking testbench for the two-channel lamp fade mixer.
module tb_two_channel_lamp_fade_mixer;
    import tclfm_pkg::*;

    // Clock, run length and the settle time after the last result. The duty
    // pipeline is four registers deep, and the settle time covers it with margin.
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;

    // One request as it goes into the block.
    typedef struct packed {
        logic       kind;
        logic [7:0] bri;
        logic [7:0] col;
    } t_lamp_req;

    // One fade step as it comes out of the block.
    typedef struct packed {
        logic [9:0] warm;
        logic       warm_on;
        logic [9:0] cold;
        logic       cold_on;
        logic [6:0] level;
        logic [6:0] colour;
    } t_lamp_step;

    // Patterns the result side switches between when it stalls.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS,
        STALL_TOGGLE
    } t_stall_mode;

    // Every input starts at a known value; reset is held low from time zero.
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       i_req_type = REQ_TICK;
    logic [7:0] i_set_brightness = 8'd0;
    logic [7:0] i_target_colour = 8'd0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = CFG_BRIGHTNESS_MAX;
    logic [7:0] i_cfg_data = 8'd0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic [9:0] o_warm_duty;
    logic       o_warm_active;
    logic [9:0] o_cold_duty;
    logic       o_cold_active;
    logic [6:0] o_level_now;
    logic [6:0] o_colour_now;

    two_channel_lamp_fade_mixer #(
        .FULL_DUTY(FULL_DUTY_DEFAULT)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_req_type         (i_req_type),
        .i_set_brightness   (i_set_brightness),
        .i_target_colour    (i_target_colour),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_warm_duty        (o_warm_duty),
        .o_warm_active      (o_warm_active),
        .o_cold_duty        (o_cold_duty),
        .o_cold_active      (o_cold_active),
        .o_level_now        (o_level_now),
        .o_colour_now       (o_colour_now),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Requests waiting to be sent, and fade steps the block still owes us.
    t_lamp_req  requests_to_send[$];
    t_lamp_step steps_due[$];
    int         mismatches = 0;
    int         results_seen = 0;
    int         cycles = 0;

    // Our own copy of the configuration registers. The two default registers
    // only act at reset, which happens once, so writes to them change nothing
    // that can be observed afterwards and they are not mirrored.
    logic [6:0] cfg_bmax, cfg_bmin, cfg_cmax;
    logic [7:0] cfg_keep, cfg_off;
    logic       cfg_dimmer;

    // Our own copy of the fader state.
    logic        fade_on;
    logic [8:0]  step_no;
    logic [4:0]  pace_no;
    logic [15:0] lvl_acc, col_acc;
    logic [7:0]  lvl_delta, col_delta;
    logic [6:0]  preset_lvl, preset_col, cur_lvl, cur_col;

    task automatic reset_fader();
        cfg_bmax   = BRIGHTNESS_MAX_RST;
        cfg_bmin   = BRIGHTNESS_MIN_RST;
        cfg_cmax   = COLOUR_MAX_RST;
        cfg_keep   = KEEP_CODE_RST;
        cfg_off    = OFF_CODE_RST;
        cfg_dimmer = 1'b1;
        fade_on    = 1'b0;
        step_no    = '0;
        pace_no    = '0;
        lvl_acc    = '0;
        col_acc    = '0;
        lvl_delta  = '0;
        col_delta  = '0;
        preset_lvl = DEFAULT_LEVEL_RST;
        preset_col = DEFAULT_COLOUR_RST;
        cur_lvl    = '0;
        cur_col    = DEFAULT_COLOUR_RST;
    endtask

    // A duty exactly at full scale is pushed past it so the PWM stays high;
    // anything above the 10-bit range saturates.
    function automatic logic [9:0] finish_duty(input int unsigned d);
        if (d == FULL_DUTY_DEFAULT)
            d = d + 4;
        return (d > 1023) ? 10'd1023 : d[9:0];
    endfunction

    // Applies one request to the fader copy. Returns 1 when the request
    // completes a fade step, with the step's outputs in res.
    function automatic bit advance_fader(input t_lamp_req rq, output t_lamp_step res);
        int unsigned b, c, hold, eb, ec, warm, cold, pm;
        res = '0;
        pm  = 32'(PERMILLE_FULL);
        if (rq.kind == REQ_SET) begin
            b = 32'(rq.bri);
            c = 32'(rq.col);
            if (b == cfg_keep)
                b = 32'(preset_lvl);
            if (c == cfg_keep)
                c = 32'(preset_col);
            // The accumulators snap to the current level on any set request,
            // accepted or not, even in the middle of a fade.
            lvl_acc = 16'(cur_lvl) * ACC_SCALE;
            col_acc = 16'(cur_col) * ACC_SCALE;
            if (b <= cfg_bmax && b >= cfg_bmin && c <= cfg_cmax && cfg_dimmer) begin
                preset_lvl = b[6:0];
                preset_col = c[6:0];
                lvl_delta  = b[7:0] - {1'b0, cur_lvl};
                col_delta  = c[7:0] - {1'b0, cur_col};
                fade_on    = 1'b1;
                step_no    = '0;
            end else if (b == cfg_off) begin
                // Fade to dark, colour held. This works with the dimmer off.
                lvl_delta = 8'd0 - {1'b0, cur_lvl};
                col_delta = '0;
                fade_on   = 1'b1;
                step_no   = '0;
            end
            return 1'b0;
        end

        if (!fade_on)
            return 1'b0;

        // Near the end of a fade each step waits for several ticks.
        if (step_no >= PACE_TH_20)
            hold = 32'(PACE_LIMIT);
        else if (step_no >= PACE_TH_16)
            hold = 16;
        else if (step_no >= PACE_TH_6)
            hold = 6;
        else if (step_no >= PACE_TH_4)
            hold = 4;
        else if (step_no >= PACE_TH_2)
            hold = 2;
        else
            hold = 0;
        if (hold != 0) begin
            pace_no = pace_no + 5'd1;
            if (pace_no < hold)
                return 1'b0;
            pace_no = '0;
        end

        step_no = step_no + 9'd1;
        lvl_acc = lvl_acc + {{8{lvl_delta[7]}}, lvl_delta};
        col_acc = col_acc + {{8{col_delta[7]}}, col_delta};
        if (step_no >= FADE_STEPS) begin
            fade_on = 1'b0;
            step_no = '0;
        end

        // Brightness and colour in tenths of a percent.
        eb = 32'(lvl_acc) / 50;
        ec = 32'(col_acc) / 50;
        cur_lvl = (eb / 10 > 127) ? 7'd127 : 7'(eb / 10);
        cur_col = (ec / 10 > 127) ? 7'd127 : 7'(ec / 10);
        warm = (eb * ec) / pm;
        cold = (ec > pm) ? 0 : ((pm - ec) * eb) / pm;

        res.warm    = finish_duty(warm);
        res.warm_on = (res.warm != 0);
        res.cold    = finish_duty(cold);
        res.cold_on = (res.cold != 0);
        res.level   = cur_lvl;
        res.colour  = cur_col;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH result %0d %s: got %0d, expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // Random request. Set requests lean towards codes and in-range values so
    // that most of them really start a fade; the rest are arbitrary bytes.
    function automatic t_lamp_req random_request(input int set_pct);
        t_lamp_req rq;
        rq.kind = ($urandom_range(99) < set_pct) ? REQ_SET : REQ_TICK;
        rq.bri  = 8'($urandom_range(255));
        rq.col  = 8'($urandom_range(255));
        if (rq.kind == REQ_SET) begin
            case ($urandom_range(9))
                0: rq.bri = cfg_keep;
                1: rq.bri = cfg_off;
                2, 3, 4, 5, 6: begin
                    if (cfg_bmin <= cfg_bmax)
                        rq.bri = 8'($urandom_range(cfg_bmax, cfg_bmin));
                end
                default: ;
            endcase
            case ($urandom_range(6))
                0: rq.col = cfg_keep;
                1, 2, 3, 4: rq.col = 8'($urandom_range(cfg_cmax, 0));
                default: ;
            endcase
        end
        return rq;
    endfunction

    // Gap before the next burst: often none, sometimes short, sometimes long.
    function automatic int pick_gap();
        case ($urandom_range(3))
            0, 1: return 0;
            2: return $urandom_range(3, 1);
            default: return $urandom_range(12, 4);
        endcase
    endfunction

    // Request driver. The sender works in bursts; a request that is stalled
    // is held unchanged until it is taken. An accepted request goes through
    // the fader copy right away, so expectations line up in request order.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_lamp_step res;
        if (i_in_valid && !o_in_stall) begin
            if (advance_fader(requests_to_send[0], res))
                steps_due.push_back(res);
            void'(requests_to_send.pop_front());
        end
        if (i_in_valid && o_in_stall) begin
            // Hold the current request.
        end else if (gap_left > 0) begin
            gap_left--;
            i_in_valid <= 1'b0;
        end else if (requests_to_send.size() != 0) begin
            i_in_valid       <= 1'b1;
            i_req_type       <= requests_to_send[0].kind;
            i_set_brightness <= requests_to_send[0].bri;
            i_target_colour  <= requests_to_send[0].col;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(40, 1);
                gap_left   = pick_gap();
            end else begin
                burst_left--;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Result monitor and stall pattern. The stall mode changes every so
    // often: never stall, random stalls, long runs that fill the pipeline
    // and push back on requests, or a stall that toggles.
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 50;
    int          run_left = 0;
    logic        run_high = 1'b0;

    always @(posedge i_clk) begin
        t_lamp_step want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (steps_due.size() == 0) begin
                report_mismatch("with nothing due, level_now", int'(o_level_now), -1);
            end else begin
                want = steps_due.pop_front();
                if (o_warm_duty !== want.warm)
                    report_mismatch("warm_duty", int'(o_warm_duty), int'(want.warm));
                if (o_warm_active !== want.warm_on)
                    report_mismatch("warm_active", int'(o_warm_active),
                                    int'(want.warm_on));
                if (o_cold_duty !== want.cold)
                    report_mismatch("cold_duty", int'(o_cold_duty), int'(want.cold));
                if (o_cold_active !== want.cold_on)
                    report_mismatch("cold_active", int'(o_cold_active),
                                    int'(want.cold_on));
                if (o_level_now !== want.level)
                    report_mismatch("level_now", int'(o_level_now), int'(want.level));
                if (o_colour_now !== want.colour)
                    report_mismatch("colour_now", int'(o_colour_now), int'(want.colour));
            end
        end

        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(3));
            mode_left  = $urandom_range(200, 20);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            STALL_NONE: i_out_stall <= 1'b0;
            STALL_RANDOM: i_out_stall <= ($urandom_range(2) == 0);
            STALL_RUNS: begin
                if (run_left == 0) begin
                    run_high = !run_high;
                    run_left = run_high ? $urandom_range(40, 5) : $urandom_range(10, 1);
                end else begin
                    run_left--;
                end
                i_out_stall <= run_high;
            end
            default: i_out_stall <= !i_out_stall;
        endcase
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_two_channel_lamp_fade_mixer: done, errors");
            $finish;
        end
    end

    task automatic send(input logic kind, input logic [7:0] bri, input logic [7:0] col);
        t_lamp_req rq;
        rq.kind = kind;
        rq.bri  = bri;
        rq.col  = col;
        requests_to_send.push_back(rq);
    endtask

    task automatic send_random(input int count, input int set_pct);
        for (int n = 0; n < count; n++)
            requests_to_send.push_back(random_request(set_pct));
    endtask

    // Waits until every request is sent and every step has come back, then
    // gives the pipeline time to show anything it should not.
    task automatic wait_idle();
        while (requests_to_send.size() != 0 || i_in_valid || steps_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BRIGHTNESS_MAX: cfg_bmax   = val[6:0];
            CFG_BRIGHTNESS_MIN: cfg_bmin   = val[6:0];
            CFG_COLOUR_MAX:     cfg_cmax   = val[6:0];
            CFG_KEEP_CODE:      cfg_keep   = val;
            CFG_OFF_CODE:       cfg_off    = val;
            CFG_DIMMER_ON:      cfg_dimmer = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] bmax, input logic [7:0] bmin,
                              input logic [7:0] cmax, input logic [7:0] keep,
                              input logic [7:0] off, input logic [7:0] dimmer,
                              input logic [7:0] def_b, input logic [7:0] def_c);
        write_reg(CFG_BRIGHTNESS_MAX, bmax);
        write_reg(CFG_BRIGHTNESS_MIN, bmin);
        write_reg(CFG_COLOUR_MAX, cmax);
        write_reg(CFG_KEEP_CODE, keep);
        write_reg(CFG_OFF_CODE, off);
        write_reg(CFG_DIMMER_ON, dimmer);
        write_reg(CFG_DEFAULT_BRIGHTNESS, def_b);
        write_reg(CFG_DEFAULT_COLOUR, def_c);
        @(negedge i_clk);
    endtask

    initial begin
        reset_fader();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests under the reset configuration: a tick with no
        // fade running, fades to both ends of the ranges, keep codes on one
        // and both fields, the off code, out-of-range brightness and colour,
        // and ticks carrying all-zero, all-one and alternating payloads.
        send(REQ_TICK, 8'h00, 8'h00);
        send(REQ_SET, 8'd100, 8'd0);
        send(REQ_TICK, 8'hFF, 8'hFF);
        send(REQ_TICK, 8'h55, 8'hAA);
        send(REQ_TICK, 8'hAA, 8'h55);
        send(REQ_SET, 8'd1, 8'd100);
        send(REQ_TICK, 8'h00, 8'h00);
        send(REQ_TICK, 8'h00, 8'h00);
        send(REQ_SET, KEEP_CODE_RST, KEEP_CODE_RST);
        send(REQ_TICK, 8'h00, 8'h00);
        send(REQ_SET, KEEP_CODE_RST, 8'd30);
        send(REQ_TICK, 8'h00, 8'h00);
        send(REQ_SET, OFF_CODE_RST, 8'd77);
        send(REQ_TICK, 8'h00, 8'h00);
        send(REQ_TICK, 8'h00, 8'h00);
        send(REQ_SET, 8'd101, 8'd50);
        send(REQ_SET, 8'd60, 8'd101);
        send(REQ_TICK, 8'h00, 8'h00);
        send(REQ_SET, 8'd127, 8'd127);
        send(REQ_TICK, 8'h00, 8'h00);
        send(REQ_SET, 8'd100, 8'd100);
        send(REQ_TICK, 8'hFF, 8'h00);
        send(REQ_TICK, 8'h00, 8'hFF);
        wait_idle();

        // One whole fade, through every pacing band to its end, with two
        // rejected requests that snap the accumulators but keep the step.
        send(REQ_SET, 8'd90, 8'd20);
        for (int n = 0; n < 990; n++) begin
            if (n == 200 || n == 700)
                send(REQ_SET, 8'd101, 8'd50);
            else
                requests_to_send.push_back(random_request(0));
        end
        wait_idle();

        // Widest ranges, keep and off codes the same value: levels and
        // colours above 100 percent, saturated warm and silent cold duties.
        set_config(8'd127, 8'd0, 8'd127, 8'd0, 8'd0, 8'd1, 8'd0, 8'd127);
        send_random(30, 20);
        wait_idle();

        // Dimmer off: only the off code can start a fade.
        set_config(8'd100, 8'd1, 8'd100, 8'd17, 8'd200, 8'd0, 8'd100, 8'd0);
        send_random(30, 25);
        wait_idle();

        // Empty ranges: every set request is rejected.
        set_config(8'd0, 8'd100, 8'd0, 8'd255, 8'd255, 8'd1, 8'd50, 8'd50);
        send_random(20, 20);
        wait_idle();

        // Arbitrary register contents, including the unused top data bits,
        // with rare set requests so fades run deeper.
        set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
        send_random(40, 1);
        wait_idle();

        // Back to the reset values.
        set_config({1'b0, BRIGHTNESS_MAX_RST}, {1'b0, BRIGHTNESS_MIN_RST},
                   {1'b0, COLOUR_MAX_RST}, KEEP_CODE_RST, OFF_CODE_RST, 8'd1,
                   {1'b0, DEFAULT_LEVEL_RST}, {1'b0, DEFAULT_COLOUR_RST});
        send_random(30, 25);
        wait_idle();

        if (mismatches == 0)
            $display("tb_two_channel_lamp_fade_mixer: done, clean");
        else
            $display("tb_two_channel_lamp_fade_mixer: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tclfm_pkg.sv
hdl/tclfm_duty_pipe.sv
hdl/two_channel_lamp_fade_mixer.sv
test/tb_two_channel_lamp_fade_mixer.sv
